>>> src/gri_pkg.sv
// Shared types and constants for the eight-channel gyro rate integrator.
// Used by gri_div1000 and gyro_rate_integrator_8ch_core; depends on nothing.
`default_nettype none

package gri_pkg;

    localparam int NUM_CH   = 8;
    localparam int CH_W     = 3;
    localparam int IDX_W    = 4;
    localparam int ACC_W    = 64;
    localparam int ANGLE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 64;
    localparam int DIFF_W   = 34;
    localparam int DMAG_W   = 33;
    localparam int GMAG_W   = 32;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 24;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int GU_W     = 48;
    localparam int INC_W    = 48;
    localparam int PROD_W   = 81;

    localparam int DIGIT_W  = 8;
    localparam int DIV_STEPS = ACC_W / DIGIT_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);
    localparam int REM_W    = 10;
    localparam logic [REM_W:0] NANO_PER_MICRO = 11'd1000;

    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_REPORT    = 1'b1;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] value;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> src/gri_div1000.sv
// Iterative signed divide-by-1000 of a 64-bit integrator, eight bits per step.
// Returns the low 32 bits of the quotient truncated toward zero; uses gri_pkg.
`default_nettype none

module gri_div1000
    import gri_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic                r_neg;
    logic [ACC_W-1:0]    r_dvd;
    logic [REM_W-1:0]    r_rem;
    logic [ANGLE_W-1:0]  r_quo;

    logic [REM_W-1:0]    n_rem;
    logic [DIGIT_W-1:0]  n_digit;

    always_comb begin
        logic [REM_W:0] x;
        logic [REM_W-1:0] rem;
        rem = r_rem;
        n_digit = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            x = {rem, r_dvd[ACC_W-1-k]};
            if (x >= NANO_PER_MICRO) begin
                x = x - NANO_PER_MICRO;
                n_digit[DIGIT_W-1-k] = 1'b1;
            end
            rem = x[REM_W-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.value[ACC_W-1];
            r_dvd <= i_req.value[ACC_W-1] ? (ACC_W'(0) - i_req.value) : i_req.value;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << DIGIT_W;
            r_rem <= n_rem;
            r_quo <= {r_quo[ANGLE_W-DIGIT_W-1:0], n_digit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (ANGLE_W'(0) - r_quo) : r_quo;

endmodule

`default_nettype wire

>>> src/gyro_rate_integrator_8ch_core.sv
// Eight-channel gyro rate integrator: top level with sequencer, shared multiplier,
// coefficient registers and integrators. Depends on gri_pkg and gri_div1000.
//
// Each item is taken only while the block is idle (o_in_stall low) and holds the
// block for its whole run. An integrate item (op 0) integrates and then reports; a
// report-only item (op 1) only reports. Integration visits the channels one by one
// through a single 33x24 multiplier, in the steps prepare, gain times elapsed time,
// two partial products, sum and accumulate. The report then runs each integrator
// through a divide-by-1000 unit that retires eight dividend bits a cycle. The
// result item stays on the o_angle_ch* ports until taken; the report phase of the
// following item waits for that. Coefficient writes go to i_cfg_idx 0..7 and take
// effect at once; indexes 8..15 are ignored.
`default_nettype none

module gyro_rate_integrator_8ch_core
    import gri_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_W-1:0]    i_cfg_idx,
    input  wire logic [COEF_W-1:0]   i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_op,
    input  wire logic [SAMPLE_W-1:0] i_elapsed_us,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch0,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch1,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch2,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch3,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch4,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch5,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch6,
    input  wire logic [SAMPLE_W-1:0] i_sample_ch7,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [ANGLE_W-1:0]       o_angle_ch0,
    output logic [ANGLE_W-1:0]       o_angle_ch1,
    output logic [ANGLE_W-1:0]       o_angle_ch2,
    output logic [ANGLE_W-1:0]       o_angle_ch3,
    output logic [ANGLE_W-1:0]       o_angle_ch4,
    output logic [ANGLE_W-1:0]       o_angle_ch5,
    output logic [ANGLE_W-1:0]       o_angle_ch6,
    output logic [ANGLE_W-1:0]       o_angle_ch7
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PREP   = 10'b00_0000_0010,
        S_GU     = 10'b00_0000_0100,
        S_PLO    = 10'b00_0000_1000,
        S_PHI    = 10'b00_0001_0000,
        S_SUM    = 10'b00_0010_0000,
        S_ACC    = 10'b00_0100_0000,
        S_GATE   = 10'b00_1000_0000,
        S_DSTART = 10'b01_0000_0000,
        S_DWAIT  = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CH_W-1:0]      r_ch;
    logic                 r_out_valid;

    logic [COEF_W-1:0]    r_coef  [NUM_CH];
    logic [ACC_W-1:0]     r_acc   [NUM_CH];
    logic [SAMPLE_W-1:0]  r_smp   [NUM_CH];
    logic [ANGLE_W-1:0]   r_angle [NUM_CH];
    logic [SAMPLE_W-1:0]  r_us;

    logic [DMAG_W-1:0]    r_dmag;
    logic [GMAG_W-1:0]    r_gmag;
    logic                 r_neg;
    logic [GU_W-1:0]      r_gu;
    logic [MUL_P_W-1:0]   r_plo;
    logic [MUL_P_W-1:0]   r_phi;
    logic [INC_W-1:0]     r_m;

    logic                 in_acc;
    logic                 out_acc;
    logic                 last_ch;
    logic [COEF_W-1:0]    coef;
    logic [DIFF_W-1:0]    diff;
    logic [GMAG_W-1:0]    gain;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic [PROD_W-1:0]    prod;
    logic [ACC_W-1:0]     inc;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign last_ch    = (r_ch == CH_W'(NUM_CH - 1));

    assign coef = r_coef[r_ch];
    assign gain = coef[GMAG_W-1:0];
    assign diff = {{2{r_smp[r_ch][SAMPLE_W-1]}}, r_smp[r_ch], 16'd0}
                - {{2{coef[COEF_W-1]}}, coef[COEF_W-1:32]};

    always_comb begin
        case (r_state)
            S_GU: begin
                mul_a = MUL_A_W'(r_gmag);
                mul_b = MUL_B_W'(r_us);
            end
            S_PHI: begin
                mul_a = r_dmag;
                mul_b = r_gu[GU_W-1:MUL_B_W];
            end
            default: begin
                mul_a = r_dmag;
                mul_b = r_gu[MUL_B_W-1:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = {r_phi, 24'd0} + PROD_W'(r_plo);
    assign inc   = r_neg ? (ACC_W'(0) - ACC_W'(r_m)) : ACC_W'(r_m);

    assign div_req.start = (r_state == S_DSTART);
    assign div_req.value = r_acc[r_ch];

    gri_div1000 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_op == OP_REPORT) ? S_GATE : S_PREP;
                end
            end
            S_PREP:   n_state = S_GU;
            S_GU:     n_state = S_PLO;
            S_PLO:    n_state = S_PHI;
            S_PHI:    n_state = S_SUM;
            S_SUM:    n_state = S_ACC;
            S_ACC:    n_state = last_ch ? S_GATE : S_PREP;
            S_GATE: begin
                if (!r_out_valid || out_acc) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = last_ch ? S_IDLE : S_DSTART;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_coef[i] <= '0;
                r_acc[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx < IDX_W'(NUM_CH))) begin
                r_coef[i_cfg_idx[CH_W-1:0]] <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_ch <= '0;
            end else if ((r_state == S_ACC) || ((r_state == S_DWAIT) && div_rsp.done)) begin
                r_ch <= r_ch + 1'b1;
            end
            if (r_state == S_ACC) begin
                r_acc[r_ch] <= r_acc[r_ch] + inc;
            end
            if ((r_state == S_DWAIT) && div_rsp.done && last_ch) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_us     <= i_elapsed_us;
            r_smp[0] <= i_sample_ch0;
            r_smp[1] <= i_sample_ch1;
            r_smp[2] <= i_sample_ch2;
            r_smp[3] <= i_sample_ch3;
            r_smp[4] <= i_sample_ch4;
            r_smp[5] <= i_sample_ch5;
            r_smp[6] <= i_sample_ch6;
            r_smp[7] <= i_sample_ch7;
        end
        if (r_state == S_PREP) begin
            r_dmag <= diff[DIFF_W-1] ? DMAG_W'(DIFF_W'(0) - diff) : diff[DMAG_W-1:0];
            r_gmag <= gain[GMAG_W-1] ? (GMAG_W'(0) - gain) : gain;
            r_neg  <= diff[DIFF_W-1] ^ gain[GMAG_W-1];
        end
        if (r_state == S_GU) begin
            r_gu <= mul_p[GU_W-1:0];
        end
        if (r_state == S_PLO) begin
            r_plo <= mul_p;
        end
        if (r_state == S_PHI) begin
            r_phi <= mul_p;
        end
        if (r_state == S_SUM) begin
            r_m <= prod[INC_W+31:32];
        end
        if ((r_state == S_DWAIT) && div_rsp.done) begin
            r_angle[r_ch] <= div_rsp.quo;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_angle_ch0 = r_angle[0];
    assign o_angle_ch1 = r_angle[1];
    assign o_angle_ch2 = r_angle[2];
    assign o_angle_ch3 = r_angle[3];
    assign o_angle_ch4 = r_angle[4];
    assign o_angle_ch5 = r_angle[5];
    assign o_angle_ch6 = r_angle[6];
    assign o_angle_ch7 = r_angle[7];

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTART) |-> !r_out_valid)
        else $error("report phase started while a result item was pending");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DWAIT))
        else $error("divider finished outside its wait state");

    a_valid_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DWAIT) && (r_state == S_IDLE))
        else $error("result item raised without finishing the last channel");

endmodule

`default_nettype wire

>>> tb/gyro_rate_integrator_8ch_core_test.sv
// Self-checking testbench for gyro_rate_integrator_8ch_core: a directed table, then random
// frames under bursty input and output stalls, checked against an in-bench integrator model.
// Depends on gri_pkg and the core RTL only.
`timescale 1ns / 100ps

module gyro_rate_integrator_8ch_core_test
    import gri_pkg::*;
();

    localparam logic [COEF_W-1:0] COEF_UNITY       = 64'h0000_0000_0001_0000;
    localparam logic [COEF_W-1:0] COEF_UNIT_OFFSET = 64'h0001_0000_0001_0000;
    localparam logic [COEF_W-1:0] COEF_MOST_NEG    = 64'h8000_0000_8000_0000;
    localparam logic [COEF_W-1:0] COEF_MOST_POS    = 64'h7fff_ffff_7fff_ffff;

    localparam int IDLE_CYCLES    = 8;
    localparam int END_CYCLES     = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 72;
    localparam int PRESSURE_PHASE = 2;
    localparam int TIMEOUT_NS     = 20_000_000;

    typedef struct packed {
        logic                             op;
        logic [SAMPLE_W-1:0]              us;
        logic [NUM_CH-1:0][SAMPLE_W-1:0]  smp;
    } t_gyro_frame;

    typedef struct packed {
        logic                set_coef;
        logic [COEF_W-1:0]   coef;
        logic                op;
        logic [SAMPLE_W-1:0] us;
        logic [SAMPLE_W-1:0] smp;
        logic                chk;
        logic [ANGLE_W-1:0]  angle;
    } t_dir_row;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [IDX_W-1:0]                 i_cfg_idx = '0;
    logic [COEF_W-1:0]                i_cfg_wdata = '0;
    logic                             i_in_valid = 1'b0;
    logic                             i_op = OP_INTEGRATE;
    logic [SAMPLE_W-1:0]              i_elapsed_us = '0;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]  sample_in = '0;
    logic                             i_out_stall = 1'b0;
    wire                              o_in_stall;
    wire                              o_out_valid;
    wire [NUM_CH-1:0][ANGLE_W-1:0]    angle_out;

    logic [COEF_W-1:0]                coef_shadow [NUM_CH];
    logic [ACC_W-1:0]                 angle_acc_nrad [NUM_CH];
    logic [NUM_CH-1:0][ANGLE_W-1:0]   angle_q [$];
    t_dir_row                         dir_rows [$];
    logic                             hold_req = 1'b0;
    int                               errors = 0;

    gyro_rate_integrator_8ch_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_elapsed_us (i_elapsed_us),
        .i_sample_ch0 (sample_in[0]),
        .i_sample_ch1 (sample_in[1]),
        .i_sample_ch2 (sample_in[2]),
        .i_sample_ch3 (sample_in[3]),
        .i_sample_ch4 (sample_in[4]),
        .i_sample_ch5 (sample_in[5]),
        .i_sample_ch6 (sample_in[6]),
        .i_sample_ch7 (sample_in[7]),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_angle_ch0  (angle_out[0]),
        .o_angle_ch1  (angle_out[1]),
        .o_angle_ch2  (angle_out[2]),
        .o_angle_ch3  (angle_out[3]),
        .o_angle_ch4  (angle_out[4]),
        .o_angle_ch5  (angle_out[5]),
        .o_angle_ch6  (angle_out[6]),
        .o_angle_ch7  (angle_out[7])
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [ACC_W-1:0] rate_increment(input logic [SAMPLE_W-1:0] smp,
            input logic [COEF_W-1:0] c, input logic [SAMPLE_W-1:0] us);
        logic [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0] dmag;
        logic [GMAG_W-1:0] gmag;
        logic [127:0]      prod;
        logic [ACC_W-1:0]  m;
        diff = {{2{smp[SAMPLE_W-1]}}, smp, 16'h0000} - {{2{c[63]}}, c[63:32]};
        dmag = diff[DIFF_W-1] ? -diff : diff;
        gmag = c[31] ? -c[31:0] : c[31:0];
        prod = {94'b0, dmag} * {96'b0, gmag} * {112'b0, us};
        m = prod[95:32];
        return (diff[DIFF_W-1] ^ c[31]) ? -m : m;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_report(input logic [ACC_W-1:0] a);
        logic [ACC_W-1:0] q;
        q = (a[ACC_W-1] ? -a : a) / NANO_PER_MICRO;
        if (a[ACC_W-1])
            q = -q;
        return q[ANGLE_W-1:0];
    endfunction

    function automatic logic [NUM_CH-1:0][ANGLE_W-1:0] advance_integrators(
            input t_gyro_frame f);
        logic [NUM_CH-1:0][ANGLE_W-1:0] rep;
        int c;
        for (c = 0; c < NUM_CH; c++) begin
            if (f.op == OP_INTEGRATE)
                angle_acc_nrad[c] += rate_increment(f.smp[c], coef_shadow[c], f.us);
            rep[c] = angle_report(angle_acc_nrad[c]);
        end
        return rep;
    endfunction

    function automatic void add_row(input logic set_coef, input logic [COEF_W-1:0] coef,
            input logic op, input logic [SAMPLE_W-1:0] us, input logic [SAMPLE_W-1:0] smp,
            input logic chk, input logic [ANGLE_W-1:0] angle);
        t_dir_row r;
        r.set_coef = set_coef;
        r.coef     = coef;
        r.op       = op;
        r.us       = us;
        r.smp      = smp;
        r.chk      = chk;
        r.angle    = angle;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0001_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_gyro_frame random_frame();
        t_gyro_frame f;
        int c;
        f.op = ($urandom_range(4) == 0) ? OP_REPORT : OP_INTEGRATE;
        case ($urandom_range(7))
            0: f.us = '0;
            1: f.us = '1;
            2: f.us = SAMPLE_W'($urandom_range(1, 50));
            default: f.us = SAMPLE_W'($urandom_range(65535));
        endcase
        for (c = 0; c < NUM_CH; c++) begin
            case ($urandom_range(9))
                0: f.smp[c] = 16'h7fff;
                1: f.smp[c] = 16'h8000;
                2: f.smp[c] = '0;
                3: f.smp[c] = '1;
                default: f.smp[c] = SAMPLE_W'($urandom_range(65535));
            endcase
        end
        return f;
    endfunction

    task automatic offer_frame(input t_gyro_frame f, input logic chk,
            input logic [NUM_CH-1:0][ANGLE_W-1:0] typed);
        logic [NUM_CH-1:0][ANGLE_W-1:0] pred;
        i_in_valid   <= 1'b1;
        i_op         <= f.op;
        i_elapsed_us <= f.us;
        sample_in    <= f.smp;
        do @(posedge i_clk); while (o_in_stall);
        pred = advance_integrators(f);
        angle_q.push_back(chk ? typed : pred);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_block_idle();
        i_in_valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // write every channel, then one out-of-range index that must be dropped
    task automatic load_coefs(input logic [NUM_CH-1:0][COEF_W-1:0] vals);
        int c;
        for (c = 0; c < NUM_CH; c++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= IDX_W'(c);
            i_cfg_wdata <= vals[c];
            coef_shadow[c] = vals[c];
            @(posedge i_clk);
        end
        i_cfg_idx   <= IDX_W'($urandom_range(NUM_CH, 2**IDX_W - 1));
        i_cfg_wdata <= {$urandom(), $urandom()};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : receiver
        int pct;
        int span;
        int hold;
        pct  = 0;
        span = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                if (span == 0) begin
                    span = $urandom_range(16, 96);
                    case ($urandom_range(4))
                        0, 1: pct = 0;
                        2: pct = 30;
                        3: pct = 60;
                        default: pct = 90;
                    endcase
                end
                span--;
                i_out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [NUM_CH-1:0][ANGLE_W-1:0] want;
        int c;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (angle_q.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                want = angle_q.pop_front();
                for (c = 0; c < NUM_CH; c++) begin
                    if (angle_out[c] !== want[c]) begin
                        $error("angle_ch%0d: expected %h, got %h", c, want[c], angle_out[c]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_gyro_frame                     f;
        logic [NUM_CH-1:0][COEF_W-1:0]   vals;
        int                              c;
        int                              p;
        int                              n;
        int                              burst;

        for (c = 0; c < NUM_CH; c++) begin
            coef_shadow[c]    = '0;
            angle_acc_nrad[c] = '0;
        end

        // reset coefficients: zero gain, nothing integrates
        add_row(0, '0, OP_INTEGRATE, 16'hffff, 16'h7fff, 1, 32'd0);
        add_row(0, '0, OP_INTEGRATE, 16'hffff, 16'h8000, 1, 32'd0);
        add_row(0, '0, OP_REPORT,    16'h1234, 16'h1234, 1, 32'd0);
        // unity gain: increment is sample times elapsed
        add_row(1, COEF_UNITY, OP_INTEGRATE, 16'd1000, 16'h0001, 1, 32'd1);
        add_row(0, '0, OP_INTEGRATE, 16'd0,    16'h7fff, 1, 32'd1);
        add_row(0, '0, OP_REPORT,    16'hffff, 16'h8000, 1, 32'd1);
        add_row(0, '0, OP_INTEGRATE, 16'd1000, 16'hffff, 1, 32'd0);
        add_row(0, '0, OP_INTEGRATE, 16'd1500, 16'hffff, 1, 32'hffff_ffff);
        add_row(0, '0, OP_INTEGRATE, 16'd999,  16'h0001, 1, 32'd0);
        // unit offset cancels a sample of one
        add_row(1, COEF_UNIT_OFFSET, OP_INTEGRATE, 16'hffff, 16'h0001, 1, 32'd0);
        add_row(0, '0, OP_INTEGRATE, 16'd2000, 16'h0000, 1, 32'hffff_fffe);
        add_row(0, '0, OP_INTEGRATE, 16'hffff, 16'h7fff, 0, '0);
        add_row(0, '0, OP_INTEGRATE, 16'hffff, 16'h8000, 0, '0);
        add_row(1, COEF_MOST_NEG, OP_INTEGRATE, 16'hffff, 16'h7fff, 0, '0);
        add_row(0, '0, OP_INTEGRATE, 16'hffff, 16'h8000, 0, '0);
        add_row(0, '0, OP_REPORT,    16'h0000, 16'h0000, 0, '0);
        // largest increments push the quotient past 32 bits
        add_row(1, COEF_MOST_POS, OP_INTEGRATE, 16'hffff, 16'h8000, 0, '0);
        add_row(0, '0, OP_INTEGRATE, 16'hffff, 16'h8000, 0, '0);
        add_row(0, '0, OP_INTEGRATE, 16'h0001, 16'h0000, 0, '0);
        add_row(1, '1, OP_INTEGRATE, 16'hffff, 16'h7fff, 0, '0);
        add_row(0, '0, OP_REPORT,    16'hffff, 16'hffff, 0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].set_coef) begin
                wait_block_idle();
                load_coefs({NUM_CH{dir_rows[r].coef}});
            end
            f.op  = dir_rows[r].op;
            f.us  = dir_rows[r].us;
            f.smp = {NUM_CH{dir_rows[r].smp}};
            offer_frame(f, dir_rows[r].chk, {NUM_CH{dir_rows[r].angle}});
            sender_gap($urandom_range(0, 3));
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_block_idle();
            for (c = 0; c < NUM_CH; c++)
                vals[c] = {pick_q16(), pick_q16()};
            load_coefs(vals);
            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;
            burst = $urandom_range(1, 12);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                offer_frame(random_frame(), 1'b0, '0);
                if (p != PRESSURE_PHASE) begin
                    if (burst == 0) begin
                        burst = $urandom_range(1, 12);
                        sender_gap($urandom_range(1, 24));
                    end else begin
                        burst--;
                    end
                end
            end
        end

        wait_block_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
src/gri_pkg.sv
src/gri_div1000.sv
src/gyro_rate_integrator_8ch_core.sv
tb/gyro_rate_integrator_8ch_core_test.sv
